### hdl/header_end_marker_deframer_core_macros.svh
// Assertion helpers for the deframer.
`ifndef HEADER_END_MARKER_DEFRAMER_CORE_MACROS_SVH
`define HEADER_END_MARKER_DEFRAMER_CORE_MACROS_SVH

// Property holds at every clock edge outside reset.
`define HEMD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define HEMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/hemd_pkg.sv
`default_nettype none
package hemd_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 64;
  localparam int unsigned MAX_ITEMS       = 62;
  localparam int unsigned LIMIT_W         = 6;
  localparam int unsigned BYTE_W          = 8;

  localparam logic [LIMIT_W-1:0] MAX_PAYLOAD_RST = 6'd31;
  localparam logic [LIMIT_W-1:0] MAX_ITEMS_V     = 6'd62;

  localparam logic [BYTE_W-1:0] CH_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_B = 8'h42;
  localparam logic [BYTE_W-1:0] CH_E = 8'h45;
  localparam logic [BYTE_W-1:0] CH_N = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_D = 8'h44;

  // marker progress: bytes of "END" matched so far
  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_E    = 2'd1;
  localparam logic [1:0] MATCH_EN   = 2'd2;
  localparam logic [1:0] MATCH_END  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic              error;
    logic              last;
    logic              byte_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_tag;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/hemd_ram.sv
`default_nettype none
module hemd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hdl/hemd_ctrl.sv
`default_nettype none
module hemd_ctrl
  import hemd_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic [BYTE_W-1:0]              in_byte,
  output logic                                in_ready,
  input  wire logic [LIMIT_W-1:0]             limit,
  input  wire logic                           slot_free,
  output logic                                ram_wr_en,
  output logic [$clog2(STORE_DEPTH)-1:0]      ram_wr_addr,
  output logic [BYTE_W-1:0]                   ram_wr_data,
  output logic                                ram_rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0]      ram_rd_addr,
  input  wire logic [BYTE_W-1:0]              ram_rd_data,
  output logic                                item_load,
  output out_item_t                           item
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned FW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW = ((FW > LIMIT_W) ? FW : LIMIT_W) + 2;

  ctrl_state_t        state_r, state_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic               tag_r, tag_nxt;
  logic [1:0]         match_r, match_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [LIMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [LIMIT_W-1:0] emit_len_r, emit_len_nxt;

  logic               accept;
  logic [1:0]         nm;
  logic [CW-1:0]      fill_ext;
  logic [CW-1:0]      len_full;
  logic [LIMIT_W-1:0] len;
  logic               over;
  logic               emit_last;

  assign accept = in_valid && in_ready;

  // next marker progress; a failing byte that is 'E' restarts at one
  always_comb begin
    case (match_r)
      MATCH_E:  nm = (in_byte == CH_N) ? MATCH_EN  : ((in_byte == CH_E) ? MATCH_E : MATCH_NONE);
      MATCH_EN: nm = (in_byte == CH_D) ? MATCH_END : ((in_byte == CH_E) ? MATCH_E : MATCH_NONE);
      default:  nm = (in_byte == CH_E) ? MATCH_E : MATCH_NONE;
    endcase
  end

  assign fill_ext = CW'(fill_r);
  // "EN" of the marker sits in the store and is dropped from the payload
  assign len_full = (fill_r >= FW'(2)) ? (fill_ext - CW'(2)) : '0;
  assign len      = (len_full > CW'(MAX_ITEMS)) ? MAX_ITEMS_V : len_full[LIMIT_W-1:0];
  // confirmed payload (stored bytes minus pending partial marker) above limit
  assign over     = (fill_ext + CW'(1)) > (CW'(limit) + CW'(nm));
  assign emit_last = (emit_cnt_r + LIMIT_W'(1)) == emit_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_frame_r <= 1'b0;
      tag_r      <= 1'b0;
      match_r    <= MATCH_NONE;
      fill_r     <= '0;
      emit_cnt_r <= '0;
      emit_len_r <= '0;
    end else begin
      state_r    <= state_nxt;
      in_frame_r <= in_frame_nxt;
      tag_r      <= tag_nxt;
      match_r    <= match_nxt;
      fill_r     <= fill_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      emit_len_r <= emit_len_nxt;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    in_frame_nxt      = in_frame_r;
    tag_nxt           = tag_r;
    match_nxt         = match_r;
    fill_nxt          = fill_r;
    emit_cnt_nxt      = emit_cnt_r;
    emit_len_nxt      = emit_len_r;
    in_ready          = 1'b0;
    ram_wr_en         = 1'b0;
    ram_wr_addr       = fill_r[AW-1:0];
    ram_wr_data       = in_byte;
    ram_rd_en         = 1'b0;
    ram_rd_addr       = AW'(emit_cnt_r);
    item_load         = 1'b0;
    item.frame_tag    = tag_r;
    item.payload_byte = '0;
    item.byte_valid   = 1'b0;
    item.last         = 1'b1;
    item.error        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        if (accept) begin
          if (!in_frame_r) begin
            if (in_byte == CH_A || in_byte == CH_B) begin
              tag_nxt      = (in_byte == CH_B);
              in_frame_nxt = 1'b1;
              match_nxt    = MATCH_NONE;
              fill_nxt     = '0;
            end
          end else if (nm == MATCH_END) begin
            in_frame_nxt = 1'b0;
            match_nxt    = MATCH_NONE;
            fill_nxt     = '0;
            if (len == '0) begin
              item_load = 1'b1;
            end else begin
              emit_cnt_nxt = '0;
              emit_len_nxt = len;
              state_nxt    = ST_READ;
            end
          end else if (fill_r >= FW'(STORE_DEPTH)) begin
            item_load    = 1'b1;
            item.error   = 1'b1;
            in_frame_nxt = 1'b0;
            match_nxt    = MATCH_NONE;
            fill_nxt     = '0;
          end else begin
            ram_wr_en = 1'b1;
            fill_nxt  = fill_r + FW'(1);
            match_nxt = nm;
            if (over) begin
              item_load    = 1'b1;
              item.error   = 1'b1;
              in_frame_nxt = 1'b0;
              match_nxt    = MATCH_NONE;
              fill_nxt     = '0;
            end
          end
        end
      end
      ST_READ: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // read data holds until the next read, so waiting here is safe
        if (slot_free) begin
          item_load         = 1'b1;
          item.payload_byte = ram_rd_data;
          item.byte_valid   = 1'b1;
          item.last         = emit_last;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_cnt_nxt = emit_cnt_r + LIMIT_W'(1);
            state_nxt    = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/header_end_marker_deframer_core.sv
// Header/end-marker deframer. Bytes arrive on in_tdata. While hunting, bytes
// are dropped until 'A' (tag 0) or 'B' (tag 1) starts a frame; every byte after
// it is stored until the first "END", which is stripped. The frame then comes
// out one payload byte per item with the tag, tlast on the final one. An empty
// frame gives one item with byte_valid low. A payload over max_payload (values
// above 62 act as 62) gives one item with error set and the frame is dropped.
// A byte that does not close a frame leaves the block ready for the next byte.
// A closing "END" starts emission from the payload store, each payload byte
// taking a store read then an output load on its single read port; no input is
// taken until the final item is loaded. Input is also held off in any cycle
// where a result waits in the output register and out_tready is low. No
// clearing pass after reset.
`default_nettype none
`include "header_end_marker_deframer_core_macros.svh"
module header_end_marker_deframer_core
  import hemd_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] in_byte
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // [7:0] payload_byte
  output logic [2:0]              out_tuser,  // [0] frame_tag, [1] byte_valid, [2] error
  output logic                    out_tlast,
  // configuration: max_payload
  input  wire logic               cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [LIMIT_W-1:0] max_payload_r;
  logic [LIMIT_W-1:0] limit;

  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               slot_free;
  logic               item_load;
  out_item_t          item;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [BYTE_W-1:0]  ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [BYTE_W-1:0]  ram_rd_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  assign limit = (max_payload_r > MAX_ITEMS_V) ? MAX_ITEMS_V : max_payload_r;

  // output register: free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      out_item_r <= item;
    end
  end

  hemd_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_byte     (in_tdata),
    .in_ready    (in_tready),
    .limit       (limit),
    .slot_free   (slot_free),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .item_load   (item_load),
    .item        (item)
  );

  // payload store
  hemd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r.payload_byte;
  assign out_tuser  = {out_item_r.error, out_item_r.byte_valid, out_item_r.frame_tag};
  assign out_tlast  = out_item_r.last;

  // a pending result is never overwritten
  `HEMD_ASSERT_IMPL(a_no_overwrite, item_load, slot_free, "item loaded over pending result")
  // store writes happen while parsing, reads only while emitting
  `HEMD_ASSERT_ALWAYS(a_rw_excl, !(ram_wr_en && ram_rd_en), "store read and write overlap")
  // empty or error items carry a zero byte and close the frame
  `HEMD_ASSERT_IMPL(a_novalid_item, out_tvalid && !out_tuser[1],
                    out_tdata == '0 && out_tlast, "bad empty/error item")
  // no input is taken while a frame is being emitted
  `HEMD_ASSERT_IMPL(a_no_in_on_read, ram_rd_en, !in_tready, "input taken during emission")

endmodule
`default_nettype wire

### verif/deframe_scoreboard_pkg.sv
`timescale 1ns / 1ps
package deframe_scoreboard_pkg;
  import hemd_pkg::*;

  class deframe_scoreboard;
    logic [LIMIT_W-1:0] max_len;
    bit                 in_frame;
    bit                 tag;
    logic [1:0]         match;
    int unsigned        fill;
    logic [BYTE_W-1:0]  payload [STORE_DEPTH_DEF];
    out_item_t          expected_q[$];
    int unsigned        fails;

    function new();
      max_len  = MAX_PAYLOAD_RST;
      in_frame = 1'b0;
      tag      = 1'b0;
      match    = MATCH_NONE;
      fill     = 0;
      fails    = 0;
    endfunction

    function void set_limit(input logic [LIMIT_W-1:0] v);
      max_len = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void expect_item(input logic [BYTE_W-1:0] b, input bit valid,
                              input bit last, input bit err);
      out_item_t it;
      it.frame_tag    = tag;
      it.payload_byte = b;
      it.byte_valid   = valid;
      it.last         = last;
      it.error        = err;
      expected_q.push_back(it);
    endfunction

    function void hunt();
      in_frame = 1'b0;
      match    = MATCH_NONE;
      fill     = 0;
    endfunction

    // one accepted input byte
    function void note_byte(input logic [BYTE_W-1:0] b);
      logic [1:0]  nm;
      int unsigned len;
      int unsigned cap;
      int unsigned k;
      if (!in_frame) begin
        if (b == CH_A || b == CH_B) begin
          tag      = (b == CH_B);
          in_frame = 1'b1;
          match    = MATCH_NONE;
          fill     = 0;
        end
        return;
      end
      if (match == MATCH_E)
        nm = (b == CH_N) ? MATCH_EN : ((b == CH_E) ? MATCH_E : MATCH_NONE);
      else if (match == MATCH_EN)
        nm = (b == CH_D) ? MATCH_END : ((b == CH_E) ? MATCH_E : MATCH_NONE);
      else
        nm = (b == CH_E) ? MATCH_E : MATCH_NONE;

      if (nm == MATCH_END) begin
        // "EN" already sits in the store, strip it
        len = (fill >= 2) ? fill - 2 : 0;
        if (len > STORE_DEPTH_DEF) len = STORE_DEPTH_DEF;
        if (len > MAX_ITEMS) len = MAX_ITEMS;
        if (len == 0)
          expect_item('0, 1'b0, 1'b1, 1'b0);
        else
          for (k = 0; k < len; k++)
            expect_item(payload[k], 1'b1, (k + 1 == len), 1'b0);
        hunt();
        return;
      end

      if (fill >= STORE_DEPTH_DEF) begin
        expect_item('0, 1'b0, 1'b1, 1'b1);
        hunt();
        return;
      end
      payload[fill] = b;
      fill++;
      match = nm;
      cap = (max_len > MAX_ITEMS_V) ? MAX_ITEMS : max_len;
      if (fill - nm > cap) begin
        expect_item('0, 1'b0, 1'b1, 1'b1);
        hunt();
      end
    endfunction

    function void check_item(input out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: payload_byte %0h tag %0d error %0d",
               got.payload_byte, got.frame_tag, got.error);
        fails++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.frame_tag !== exp.frame_tag) begin
        $error("frame_tag: expected %0d, got %0d", exp.frame_tag, got.frame_tag);
        fails++;
      end
      if (got.payload_byte !== exp.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", exp.payload_byte, got.payload_byte);
        fails++;
      end
      if (got.byte_valid !== exp.byte_valid) begin
        $error("byte_valid: expected %0d, got %0d", exp.byte_valid, got.byte_valid);
        fails++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        fails++;
      end
      if (got.error !== exp.error) begin
        $error("error: expected %0d, got %0d", exp.error, got.error);
        fails++;
      end
    endfunction
  endclass

endpackage

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import hemd_pkg::*;
  import deframe_scoreboard_pkg::*;

  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int unsigned SETTLE      = 20;     // quiet cycles after the last result
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;
  logic [2:0]         out_tuser;
  logic               out_tlast;
  logic               cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;

  deframe_scoreboard sb;

  // per-side idling switches and the receiver hold-off request
  bit          tx_idle  = 1'b1;
  bit          rx_idle  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned framed_items;
  int unsigned cycles;
  logic [7:0]  script_q[$];

  header_end_marker_deframer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Result side. Draws a stall per item while rx_idle is set; on request it
  // holds tready low for a long stretch so results back up and in_tready drops.
  initial begin : result_sink
    int unsigned gap;
    out_item_t   got;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      // tuser: [0] frame_tag, [1] byte_valid, [2] error
      got.frame_tag    = out_tuser[0];
      got.byte_valid   = out_tuser[1];
      got.error        = out_tuser[2];
      got.payload_byte = out_tdata;
      got.last         = out_tlast;
      sb.check_item(got);
    end
  end

  // one byte item; the prediction is updated once the block takes it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= b;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_byte(b);
  endtask

  task automatic send_script();
    while (script_q.size() != 0) send_byte(script_q.pop_front());
  endtask

  // stray byte while hunting: anything but a header
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_A || b == CH_B) b = b ^ 8'h10;
    return b;
  endfunction

  // Payload bytes. Marker and header characters show up often so partial
  // "END" matches and embedded headers get exercised; no_e keeps the marker
  // from ever starting.
  task automatic send_body(input int unsigned n, input bit no_e);
    int unsigned k;
    logic [7:0]  b;
    for (k = 0; k < n; k++) begin
      if (!no_e && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: b = CH_E;
          1: b = CH_N;
          2: b = CH_D;
          3: b = CH_A;
          default: b = CH_B;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
        if (no_e && b == CH_E) b = 8'h65;
      end
      send_byte(b);
    end
  endtask

  // noise, header, payload, and usually the end marker (an unterminated frame
  // runs into the next one)
  task automatic send_frame(input int unsigned len);
    int unsigned n_noise;
    int unsigned k;
    n_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (k = 0; k < n_noise; k++) send_byte(noise_byte());
    send_byte($urandom_range(0, 1) ? CH_B : CH_A);
    send_body(len, 1'b0);
    if ($urandom_range(0, 9) != 0) begin
      send_byte(CH_E);
      send_byte(CH_N);
      send_byte(CH_D);
    end
    framed_items += len + 4;
  endtask

  // random frames sized around the current limit: mostly short, a good share
  // right at the limit edge, a few anywhere up to it
  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    int unsigned cap;
    int unsigned r;
    int unsigned len;
    start = framed_items;
    cap = (sb.max_len > MAX_ITEMS_V) ? MAX_ITEMS : sb.max_len;
    while (framed_items - start < n_items) begin
      r = $urandom_range(0, 9);
      if (r < 5)
        len = $urandom_range(0, 6);
      else if (r < 8)
        len = $urandom_range((cap > 2) ? cap - 2 : 0, cap + 2);
      else
        len = $urandom_range(0, cap);
      send_frame(len);
    end
  endtask

  // close any open frame, stop offering, wait for every expected item, then
  // give the block time to go quiet
  task automatic close_and_drain();
    send_byte(CH_E);
    send_byte(CH_N);
    send_byte(CH_D);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_limit(v);
  endtask

  initial begin : stimulus
    int unsigned p;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    framed_items = 0;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit. Stray bytes while hunting, an empty frame, a frame holding
    // extreme bytes and both headers (header right after the marker), a failed
    // partial match restarting on 'E', and a doubled 'E' before the marker.
    script_q = {8'h00, 8'hFF, CH_E,
                CH_A, CH_E, CH_N, CH_D,
                CH_B, 8'h00, 8'hFF, CH_A, CH_B, CH_E, CH_N, CH_D,
                CH_A, CH_E, CH_N, CH_E, CH_N, CH_D,
                CH_A, CH_E, CH_E, CH_N, CH_D};
    send_script();
    close_and_drain();

    // Limit 0: any stored byte drops the frame, even after a broken partial
    // match; only the empty frame survives.
    write_limit('0);
    script_q = {CH_A, 8'h58,
                CH_B, CH_E, CH_N, CH_D,
                CH_B, CH_E, 8'h00};
    send_script();
    run_random(20);
    close_and_drain();

    // Limit 62: a full-length frame while the receiver holds off, then a frame
    // whose pending "EN" fills the store so the next byte overflows it, then
    // one byte over the limit.
    write_limit(MAX_ITEMS_V);
    hold_req = 1'b1;
    send_byte(CH_B);
    send_body(MAX_ITEMS, 1'b1);
    script_q = {CH_E, CH_N, CH_D};
    send_script();
    send_byte(CH_A);
    send_body(MAX_ITEMS, 1'b1);
    script_q = {CH_E, CH_N, 8'h5A};
    send_script();
    send_byte(CH_A);
    send_body(MAX_ITEMS + 1, 1'b1);
    run_random(20);
    close_and_drain();

    // all-ones register acts as 62; back-to-back on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_limit('1);
    run_random(40);
    close_and_drain();

    // random limits, idling switched per side
    for (p = 0; p < 3; p++) begin
      tx_idle = (p != 1);
      rx_idle = (p != 2);
      write_limit(LIMIT_W'($urandom_range(1, MAX_ITEMS - 1)));
      run_random(25);
      close_and_drain();
    end

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_limit(6'd1);
    run_random(20);
    close_and_drain();

    if (sb.fails == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
